[rtl/mam_pkg.sv]
// ----------------------------------------------------------------------------
// mam_pkg: shared types and constants for the motion arrival monitor
// Holds the beat structs, configuration and run state, codes and thresholds.
// ----------------------------------------------------------------------------
package mam_pkg;

  localparam int unsigned PosW     = 20;
  localparam int unsigned TimeW    = 20;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned ElapsedW = 21;
  localparam int unsigned StillW   = 3;
  localparam int unsigned ErrW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // distance bands in 0.1 mm units
  localparam logic [PosW:0] StillBand     = (PosW+1)'(2);
  localparam logic [PosW:0] TargetBand    = (PosW+1)'(20);
  localparam logic [PosW:0] OvershootBand = (PosW+1)'(40);

  localparam logic [StillW-1:0]   ArriveStillMin = StillW'(5);
  localparam logic [StillW-1:0]   StillMax       = StillW'(7);
  localparam logic [ErrW-1:0]     ReadErrorMax   = ErrW'(10);
  localparam logic [ElapsedW-1:0] ElapsedMax     = {ElapsedW{1'b1}};

  localparam logic signed [PosW-1:0] PosMarker = PosW'(99999);

  localparam logic signed [PosW-1:0] TargetReset  = '0;
  localparam logic [TimeW-1:0]       TimeoutReset = TimeW'(30000);
  localparam logic [PeriodW-1:0]     PeriodReset  = PeriodW'(500);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_RDFAIL  = 2'd2,
    KIND_CANCEL  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_WAITING   = 3'd0,
    VERDICT_ARRIVED   = 3'd1,
    VERDICT_OVERSHOOT = 3'd2,
    VERDICT_TIMEOUT   = 3'd3,
    VERDICT_RDERRORS  = 3'd4,
    VERDICT_CANCELLED = 3'd5
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_POS  = 2'd0,
    CFG_TIMEOUT_MS  = 2'd1,
    CFG_POLL_PERIOD = 2'd2,
    CFG_GUARD       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [PosW-1:0] position;
  } in_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       success;
    logic       stop_request;
  } out_t;

  typedef struct packed {
    logic signed [PosW-1:0] target_pos;
    logic [TimeW-1:0]       timeout_ms;
    logic [PeriodW-1:0]     poll_period_ms;
    logic                   overshoot_guard;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] last_moving_pos;
    logic [StillW-1:0]      still_count;
    logic [ElapsedW-1:0]    elapsed_ms;
    logic [ErrW-1:0]        read_error_count;
    logic                   target_was_reached;
    logic                   run_finished;
  } state_t;

  localparam state_t StateReset = '{
    last_moving_pos:    PosMarker,
    still_count:        '0,
    elapsed_ms:         '0,
    read_error_count:   '0,
    target_was_reached: 1'b0,
    run_finished:       1'b0
  };

endpackage

[rtl/mam_judge.sv]
// ----------------------------------------------------------------------------
// mam_judge: per-beat decision logic
// Works out the verdict and the next run state for one item.
// ----------------------------------------------------------------------------
module mam_judge (
  input  mam_pkg::cfg_t   cfg_i,
  input  mam_pkg::state_t st_i,
  input  mam_pkg::in_t    item_i,
  output mam_pkg::state_t st_o,
  output mam_pkg::out_t   res_o
);

  logic signed [mam_pkg::PosW:0]   d_move, d_tgt;
  logic [mam_pkg::PosW:0]          a_move, a_tgt;
  logic [mam_pkg::StillW-1:0]      still_next;
  logic [mam_pkg::ElapsedW:0]      e_sum;
  logic [mam_pkg::ErrW-1:0]        err_next;
  logic                            near, arrive;
  mam_pkg::verdict_e               verdict;

  // full-precision distances, no wrap
  assign d_move = {item_i.position[mam_pkg::PosW-1], item_i.position}
                - {st_i.last_moving_pos[mam_pkg::PosW-1], st_i.last_moving_pos};
  assign d_tgt  = {item_i.position[mam_pkg::PosW-1], item_i.position}
                - {cfg_i.target_pos[mam_pkg::PosW-1], cfg_i.target_pos};
  assign a_move = d_move[mam_pkg::PosW] ? (mam_pkg::PosW+1)'(-d_move) : d_move;
  assign a_tgt  = d_tgt[mam_pkg::PosW]  ? (mam_pkg::PosW+1)'(-d_tgt)  : d_tgt;

  assign e_sum  = {1'b0, st_i.elapsed_ms} + (mam_pkg::ElapsedW+1)'(cfg_i.poll_period_ms);

  always_comb begin
    st_o       = st_i;
    verdict    = mam_pkg::VERDICT_WAITING;
    still_next = st_i.still_count;
    near       = 1'b0;
    arrive     = 1'b0;
    err_next   = st_i.read_error_count;

    if (item_i.kind == mam_pkg::KIND_START) begin
      st_o = mam_pkg::StateReset;
    end else if (!st_i.run_finished) begin
      case (item_i.kind)
        mam_pkg::KIND_SAMPLE: begin
          if (a_move < mam_pkg::StillBand) begin
            if (st_i.still_count < mam_pkg::StillMax) begin
              still_next = st_i.still_count + 1'b1;
            end
          end else begin
            st_o.last_moving_pos = item_i.position;
            still_next           = '0;
          end
          st_o.still_count = still_next;
          near   = a_tgt < mam_pkg::TargetBand;
          arrive = near && (still_next >= mam_pkg::ArriveStillMin);
          if (arrive) begin
            verdict = mam_pkg::VERDICT_ARRIVED;
          end else begin
            if (cfg_i.overshoot_guard) begin
              if (near) begin
                st_o.target_was_reached = 1'b1;
              end else if (a_tgt > mam_pkg::OvershootBand && st_i.target_was_reached) begin
                verdict = mam_pkg::VERDICT_OVERSHOOT;
              end
            end
            if (verdict == mam_pkg::VERDICT_WAITING) begin
              if (st_i.elapsed_ms > mam_pkg::ElapsedW'(cfg_i.timeout_ms)) begin
                verdict = mam_pkg::VERDICT_TIMEOUT;
              end else if (e_sum[mam_pkg::ElapsedW]) begin
                st_o.elapsed_ms = mam_pkg::ElapsedMax;
              end else begin
                st_o.elapsed_ms = e_sum[mam_pkg::ElapsedW-1:0];
              end
            end
          end
        end
        mam_pkg::KIND_RDFAIL: begin
          if (st_i.read_error_count < mam_pkg::ReadErrorMax) begin
            err_next = st_i.read_error_count + 1'b1;
          end
          st_o.read_error_count = err_next;
          if (err_next >= mam_pkg::ReadErrorMax) begin
            verdict = mam_pkg::VERDICT_RDERRORS;
          end
        end
        default: begin
          verdict = mam_pkg::VERDICT_CANCELLED;
        end
      endcase
      if (verdict != mam_pkg::VERDICT_WAITING) begin
        st_o.run_finished = 1'b1;
      end
    end
  end

  assign res_o.verdict      = verdict;
  assign res_o.success      = (verdict == mam_pkg::VERDICT_ARRIVED)
                           || (verdict == mam_pkg::VERDICT_OVERSHOOT)
                           || (verdict == mam_pkg::VERDICT_CANCELLED);
  assign res_o.stop_request = (verdict == mam_pkg::VERDICT_OVERSHOOT);

endmodule

[rtl/motion_arrival_monitor.sv]
// ----------------------------------------------------------------------------
// motion_arrival_monitor: arrival judge for a polled positioning axis
// Takes start, sample, read-failure and cancel beats, answers each with one
// verdict beat.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o / in_data_i): one beat per event,
//   kind plus position in 0.1 mm units; a start beat opens a fresh run
//   output channel (out_valid_o / out_ready_i / out_data_o): exactly one
//   verdict beat per input beat, in order
//   config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): single-cycle writes of
//   target, timeout, poll period and guard enable, done while the block idles
// timing
//   a beat is registered on acceptance, judged from the input register and its
//   verdict lands in the output register; one beat per cycle is sustained
//   while out_ready_i stays high; the run state is updated in the same cycle
//   the verdict is registered, so the next beat sees it straight away
// reset
//   config returns to target 0, timeout 30000 ms, period 500 ms, guard off,
//   and a run is open as after a start beat; both channels are empty
// stall
//   when the receiver holds out_ready_i low the output beat holds, the input
//   register keeps its beat and in_ready_o drops once both stages are full
// ----------------------------------------------------------------------------
module motion_arrival_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mam_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mam_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [mam_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mam_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  mam_pkg::cfg_t   cfg_q;
  mam_pkg::state_t st_q, st_d;
  mam_pkg::in_t    item_q;
  mam_pkg::out_t   res_d, res_q;
  logic            item_vld_q, out_vld_q;
  logic            adv;

  // judge stage moves on when the output register is free or being drained
  assign adv        = item_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_pos      <= mam_pkg::TargetReset;
      cfg_q.timeout_ms      <= mam_pkg::TimeoutReset;
      cfg_q.poll_period_ms  <= mam_pkg::PeriodReset;
      cfg_q.overshoot_guard <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mam_pkg::cfg_idx_e'(cfg_idx_i))
        mam_pkg::CFG_TARGET_POS:  cfg_q.target_pos     <= cfg_wdata_i[mam_pkg::PosW-1:0];
        mam_pkg::CFG_TIMEOUT_MS:  cfg_q.timeout_ms     <= cfg_wdata_i[mam_pkg::TimeW-1:0];
        mam_pkg::CFG_POLL_PERIOD: cfg_q.poll_period_ms <= cfg_wdata_i[mam_pkg::PeriodW-1:0];
        mam_pkg::CFG_GUARD:       cfg_q.overshoot_guard <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register: valid flag cleared by reset, payload only on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  mam_judge u_judge (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // run state commits together with the verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mam_pkg::StateReset;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  // a finished run only reopens through a start beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(st_q.run_finished) |-> $past(adv && item_q.kind == mam_pkg::KIND_START))
    else $error("run reopened without a start beat");

  // elapsed time only goes backwards on a start beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.elapsed_ms < $past(st_q.elapsed_ms))
      |-> $past(adv && item_q.kind == mam_pkg::KIND_START))
    else $error("elapsed time decreased within a run");

  // a non-waiting verdict leaves the run finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.verdict != mam_pkg::VERDICT_WAITING |=> st_q.run_finished)
    else $error("verdict issued but run still open");

  // stop request only goes out with an overshoot verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.stop_request |-> res_q.verdict == mam_pkg::VERDICT_OVERSHOOT)
    else $error("stop request without overshoot verdict");

endmodule

[dv/motion_arrival_monitor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_arrival_monitor_tb: self-checking bench for the arrival judge
// A queue-fed driver offers start, sample, read-failure and cancel beats, an
// in-bench judge predicts every verdict beat, and a monitor compares the
// results in order. The bench covers several register settings and several
// idling patterns, and includes one long output stall.
// ----------------------------------------------------------------------------
module motion_arrival_monitor_tb;

  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 300000;
  localparam int POS_MIN      = -524288;
  localparam int POS_MAX      = 524287;
  localparam int STILL_BAND   = 2;
  localparam int TARGET_BAND  = 20;
  localparam int OVER_BAND    = 40;
  localparam int SETTLE_MIN   = 5;
  localparam int RDFAIL_LIMIT = 10;
  localparam int MARKER_POS   = 99999;
  localparam int unsigned ELAPSED_CAP = 2097151;
  localparam int PHASE_BEATS  = 290;
  localparam int LONG_HOLD    = 400;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  mam_pkg::in_t                 in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  mam_pkg::out_t                out_data_o;
  logic                         cfg_we_i = 1'b0;
  logic [mam_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [mam_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  // beats waiting to be offered, and verdicts waiting to come back
  mam_pkg::in_t  beat_q[$];
  mam_pkg::out_t verdict_q[$];

  logic in_fire = 1'b0;
  int   send_idle_pct = 32;
  int   recv_idle_pct = 62;
  bit   hold_req = 1'b0;
  bit   hold_ack = 1'b0;
  int   hold_left = 0;
  int   mism_cnt = 0;
  int   beats_queued = 0;

  // judge's copy of the registers, at reset values
  logic signed [mam_pkg::PosW-1:0] tgt_pos   = '0;
  logic [mam_pkg::TimeW-1:0]       tmo_ms    = mam_pkg::TimeW'(30000);
  logic [mam_pkg::PeriodW-1:0]     period_ms = mam_pkg::PeriodW'(500);
  logic                            guard_on  = 1'b0;

  // judge's copy of the run state
  logic signed [mam_pkg::PosW-1:0] moving_pos;
  logic [mam_pkg::StillW-1:0]      still_cnt;
  logic [mam_pkg::ElapsedW-1:0]    elapsed;
  logic [mam_pkg::ErrW-1:0]        rdfail_cnt;
  logic                            reached;
  logic                            run_over;

  motion_arrival_monitor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // verdict prediction
  // ---------------------------------------------------------------------------

  // a fresh run: the moving position starts at the marker value
  function automatic void restart_run();
    moving_pos = mam_pkg::PosW'(MARKER_POS);
    still_cnt  = '0;
    elapsed    = '0;
    rdfail_cnt = '0;
    reached    = 1'b0;
    run_over   = 1'b0;
  endfunction

  function automatic mam_pkg::out_t judge_beat(mam_pkg::in_t b);
    mam_pkg::out_t     r;
    mam_pkg::verdict_e v;
    int                cur;
    int                step;
    int                dt;
    int unsigned       sum;
    v = mam_pkg::VERDICT_WAITING;
    if (b.kind == mam_pkg::KIND_START) begin
      restart_run();
    end else if (!run_over) begin
      case (b.kind)
        mam_pkg::KIND_SAMPLE: begin
          cur  = $signed(b.position);
          step = cur - moving_pos;
          if (step < 0) step = -step;
          // close to the last moving position counts as still, else it moves
          if (step < STILL_BAND) begin
            if (still_cnt != mam_pkg::StillW'(7)) still_cnt = still_cnt + 1'b1;
          end else begin
            moving_pos = b.position;
            still_cnt  = '0;
          end
          dt = cur - tgt_pos;
          if (dt < 0) dt = -dt;
          if (dt < TARGET_BAND && still_cnt >= SETTLE_MIN) begin
            v = mam_pkg::VERDICT_ARRIVED;
          end else begin
            if (guard_on) begin
              if (dt < TARGET_BAND) reached = 1'b1;
              else if (dt > OVER_BAND && reached) v = mam_pkg::VERDICT_OVERSHOOT;
            end
            // timeout is judged on the elapsed time before this sample's poll
            if (v == mam_pkg::VERDICT_WAITING) begin
              if (elapsed > tmo_ms) begin
                v = mam_pkg::VERDICT_TIMEOUT;
              end else begin
                sum = elapsed + period_ms;
                elapsed = (sum > ELAPSED_CAP) ? mam_pkg::ElapsedW'(ELAPSED_CAP)
                                              : mam_pkg::ElapsedW'(sum);
              end
            end
          end
        end
        mam_pkg::KIND_RDFAIL: begin
          if (rdfail_cnt < RDFAIL_LIMIT) rdfail_cnt = rdfail_cnt + 1'b1;
          if (rdfail_cnt >= RDFAIL_LIMIT) v = mam_pkg::VERDICT_RDERRORS;
        end
        default: begin
          v = mam_pkg::VERDICT_CANCELLED;
        end
      endcase
      if (v != mam_pkg::VERDICT_WAITING) run_over = 1'b1;
    end
    r.verdict      = v;
    r.success      = (v == mam_pkg::VERDICT_ARRIVED || v == mam_pkg::VERDICT_OVERSHOOT ||
                      v == mam_pkg::VERDICT_CANCELLED);
    r.stop_request = (v == mam_pkg::VERDICT_OVERSHOOT);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers beats from the queue, holds each until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= beat_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output receiver: random back-pressure, plus one long hold on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each output beat, then predicts for each accepted input
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, mam_pkg::out_t want, mam_pkg::out_t got);
    mism_cnt++;
    if (mism_cnt <= 10)
      $display({"%0t: %s: expected verdict %0d success %0d stop %0d, ",
                "got verdict %0d success %0d stop %0d"},
               $realtime, what, want.verdict, want.success, want.stop_request,
               got.verdict, got.success, got.stop_request);
  endtask

  always @(posedge clk_i) begin
    mam_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("unexpected beat", 'x, out_data_o);
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.verdict !== want.verdict || out_data_o.success !== want.success ||
              out_data_o.stop_request !== want.stop_request)
            note_mismatch("verdict mismatch", want, out_data_o);
        end
      end
      // output handled first: a beat accepted now cannot leave in this cycle
      if (in_valid_i && in_ready_o) verdict_q.push_back(judge_beat(in_data_i));
    end
    in_fire <= rst_ni && in_valid_i && in_ready_o;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // positions are clamped into the 20 bit range
  task automatic offer_beat(mam_pkg::kind_e k, int p);
    mam_pkg::in_t b;
    if (p > POS_MAX) p = POS_MAX;
    else if (p < POS_MIN) p = POS_MIN;
    b.kind     = k;
    b.position = mam_pkg::PosW'(p);
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // register writes only happen with nothing in flight
  task automatic write_reg(mam_pkg::cfg_idx_e idx, int v);
    logic [mam_pkg::CfgDataW-1:0] w;
    w = mam_pkg::CfgDataW'(v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mam_pkg::CFG_TARGET_POS:  tgt_pos   = $signed(w);
      mam_pkg::CFG_TIMEOUT_MS:  tmo_ms    = w;
      mam_pkg::CFG_POLL_PERIOD: period_ms = w[mam_pkg::PeriodW-1:0];
      default:                  guard_on  = w[0];
    endcase
  endtask

  task automatic set_regs(int tgt, int tmo, int per, int grd);
    write_reg(mam_pkg::CFG_TARGET_POS, tgt);
    write_reg(mam_pkg::CFG_TIMEOUT_MS, tmo);
    write_reg(mam_pkg::CFG_POLL_PERIOD, per);
    write_reg(mam_pkg::CFG_GUARD, grd);
  endtask

  // wait for the queue to drain and every verdict to come back
  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one plausible move: approach, settle with jitter, occasional overshoot,
  // stray read failures and cancels
  task automatic queue_move();
    int aim;
    int pos;
    int r;
    aim = tgt_pos;
    offer_beat(mam_pkg::KIND_START, spread(POS_MIN, POS_MAX));
    if ($urandom_range(19) == 0) begin
      // burst of read failures, usually enough to abort the run
      repeat ($urandom_range(12, 8))
        offer_beat(mam_pkg::KIND_RDFAIL, spread(POS_MIN, POS_MAX));
      return;
    end
    pos = aim + spread(-5000, 5000);
    repeat ($urandom_range(30, 4)) begin
      r = $urandom_range(99);
      if (r < 3) begin
        offer_beat(mam_pkg::KIND_RDFAIL, pos);
      end else if (r < 4) begin
        offer_beat(mam_pkg::KIND_CANCEL, pos);
      end else begin
        if (r < 10) begin
          pos = aim + ($urandom_range(1) ? spread(35, 60) : -spread(35, 60));
        end else if (pos - aim > 25 || aim - pos > 25) begin
          pos = pos + (aim - pos) / 2 + spread(-3, 3);
        end else if (r < 20) begin
          pos = aim + spread(-25, 25);
        end else if (r >= 70) begin
          pos = pos + spread(-2, 2);
        end
        offer_beat(mam_pkg::KIND_SAMPLE, pos);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    restart_run();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of position, the marker case, cancel, a beat after the end,
    // and the tenth read failure
    offer_beat(mam_pkg::KIND_SAMPLE, POS_MIN);
    offer_beat(mam_pkg::KIND_SAMPLE, POS_MAX);
    offer_beat(mam_pkg::KIND_START, 0);
    offer_beat(mam_pkg::KIND_SAMPLE, MARKER_POS - 1);
    offer_beat(mam_pkg::KIND_CANCEL, 0);
    offer_beat(mam_pkg::KIND_RDFAIL, 0);
    offer_beat(mam_pkg::KIND_START, 0);
    repeat (RDFAIL_LIMIT) offer_beat(mam_pkg::KIND_RDFAIL, 0);
    wait_idle();

    // overshoot stop with the guard on, then timeout with a zero budget
    set_regs(1000, 0, 1, 1);
    @(posedge clk_i);
    offer_beat(mam_pkg::KIND_START, 0);
    offer_beat(mam_pkg::KIND_SAMPLE, 1000);
    offer_beat(mam_pkg::KIND_SAMPLE, 1000 + OVER_BAND + 1);
    offer_beat(mam_pkg::KIND_START, 0);
    offer_beat(mam_pkg::KIND_SAMPLE, 0);
    offer_beat(mam_pkg::KIND_SAMPLE, 0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(spread(-3000, 3000), 6000, 500, 0);
        1: set_regs(POS_MIN, 1048575, 65535, 1);
        2: set_regs(POS_MAX, 0, 1, 0);
        3: set_regs(spread(POS_MIN, POS_MAX), 2000, 0, 1);
        4: set_regs(spread(POS_MIN, POS_MAX), spread(1000, 5000), spread(100, 700),
                    $urandom_range(1));
        default: set_regs(spread(-20000, 20000), 3000, 250, 1);
      endcase
      @(posedge clk_i);
      if (ph < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 62;
      end else if (ph < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long output stall while the sender keeps offering
      if (ph == 5) hold_req = ~hold_req;
      beats_queued = 0;
      while (beats_queued < PHASE_BEATS) begin
        if ($urandom_range(99) < 15)
          offer_beat(mam_pkg::kind_e'($urandom_range(3)), spread(POS_MIN, POS_MAX));
        else
          queue_move();
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mism_cnt == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/mam_pkg.sv
rtl/mam_judge.sv
rtl/motion_arrival_monitor.sv
dv/motion_arrival_monitor_tb.sv
